// File: design/rtt_pkg.sv
// ----------------------------------------------------------------------------
// rtt_pkg
// shared types and constants of the round trip time tracker
// ----------------------------------------------------------------------------
package rtt_pkg;

  typedef enum logic [1:0] {
    MODE_SEND  = 2'd0,
    MODE_ACK   = 2'd1,
    MODE_NACK  = 2'd2,
    MODE_STATS = 2'd3
  } mode_e;

  typedef struct packed {
    mode_e       mode;
    logic [31:0] packet_id;
    logic [63:0] time_us;
  } item_t;

  // head of the front queue as seen by the back end
  typedef struct packed {
    logic  valid;
    item_t item;
  } fe_req_t;

  typedef struct packed {
    logic        valid;
    logic        kind;
    logic        ack_ok;
    logic [31:0] rtt_us;
    logic [31:0] p50_us;
    logic [31:0] p95_us;
    logic [31:0] p99_us;
    logic [31:0] min_us;
    logic [31:0] max_us;
    logic [6:0]  fresh_count;
  } result_t;

  localparam logic [31:0] MAX_AGE_RESET = 32'd2000000;

  localparam logic [6:0] PCT_50 = 7'd50;
  localparam logic [6:0] PCT_95 = 7'd95;
  localparam logic [6:0] PCT_99 = 7'd99;

  // x / 100 == (x * 5243) >> 19 for x below 43690
  localparam logic [12:0] RECIP_100   = 13'd5243;
  localparam int          RECIP_SHIFT = 19;

endpackage

// File: design/rtt_fe.sv
// ----------------------------------------------------------------------------
// rtt_fe
// front end: takes items and holds them in a two entry queue
// ----------------------------------------------------------------------------
module rtt_fe import rtt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [1:0]  mode_i,
  input  logic [31:0] packet_id_i,
  input  logic [63:0] time_us_i,
  output logic        busy_o,
  output fe_req_t     req_o,
  input  logic        pop_i
);

  item_t       buf_q [2];
  logic        wr_q, rd_q;
  logic [1:0]  cnt_q;
  logic        push;
  item_t       item_in;

  assign busy_o = (cnt_q == 2'd2);
  assign push   = start_i && !busy_o;

  always_comb begin
    item_in.mode      = mode_e'(mode_i);
    item_in.packet_id = packet_id_i;
    item_in.time_us   = time_us_i;
  end

  assign req_o.valid = (cnt_q != 2'd0);
  assign req_o.item  = buf_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_q] <= item_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) begin
        wr_q <= ~wr_q;
      end
      if (pop_i) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop_i};
    end
  end

endmodule

// File: design/rtt_be.sv
// ----------------------------------------------------------------------------
// rtt_be
// back end: pending queue, sample ring and the statistics sequencer
// ----------------------------------------------------------------------------
module rtt_be import rtt_pkg::*; #(
  parameter int PENDING_DEPTH = 64,
  parameter int RING_DEPTH    = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [31:0] max_age_i,
  input  fe_req_t     req_i,
  output logic        pop_o,
  output result_t     res_o
);

  localparam int PD_W = $clog2(PENDING_DEPTH);
  localparam int PF_W = $clog2(PENDING_DEPTH + 1);
  localparam int RD_W = $clog2(RING_DEPTH);
  localparam int RF_W = $clog2(RING_DEPTH + 1);
  localparam int PW   = RF_W + 7;
  localparam int MW   = PW + 13;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PREAD = 4'd1;
  localparam logic [3:0] S_PCHK  = 4'd2;
  localparam logic [3:0] S_SRD   = 4'd3;
  localparam logic [3:0] S_SINS  = 4'd4;
  localparam logic [3:0] S_RANK  = 4'd5;
  localparam logic [3:0] S_RANK2 = 4'd6;
  localparam logic [3:0] S_DRAIN = 4'd7;

  function automatic logic id_less(logic [31:0] a, logic [31:0] b);
    return (a ^ 32'h8000_0000) < (b ^ 32'h8000_0000);
  endfunction

  logic [3:0]      state_q;
  item_t           item_q;
  logic [PD_W-1:0] head_q;
  logic [PF_W-1:0] pfill_q;
  logic [RD_W-1:0] wpos_q;
  logic [RF_W-1:0] rfill_q;
  logic [RF_W-1:0] idx_q, n_q, c_q;
  logic [RF_W-1:0] r50_q, r95_q, r99_q;
  logic [PW-1:0]   prod50_q, prod95_q, prod99_q;
  logic [31:0]     sort_q [RING_DEPTH];
  logic [31:0]     sort_ins [RING_DEPTH];
  result_t         res_q;

  logic [31:0] pend_id_mem   [PENDING_DEPTH];
  logic [63:0] pend_time_mem [PENDING_DEPTH];
  logic [31:0] ring_rtt_mem  [RING_DEPTH];
  logic [63:0] ring_stamp_mem[RING_DEPTH];
  logic [31:0] pend_id_rd_q;
  logic [63:0] pend_time_rd_q;
  logic [31:0] ring_rtt_rd_q;
  logic [63:0] ring_stamp_rd_q;

  // send slot
  logic            pend_full, pend_we;
  logic [PD_W-1:0] head_inc, send_head, send_slot;
  logic [PF_W-1:0] send_fill;
  logic [PF_W:0]   slot_sum;

  // ack check
  logic        pend_nonempty, hd_less, hd_eq, now_ge, ring_we;
  logic [63:0] diff;
  logic [31:0] rtt_sat;

  // stats
  logic [63:0]     age;
  logic            fresh;
  logic [RF_W-1:0] nm1;
  logic [MW-1:0]   m50, m95, m99;

  assign pop_o = (state_q == S_IDLE) && req_i.valid;
  assign res_o = res_q;

  assign pend_full = (pfill_q == PF_W'(PENDING_DEPTH));
  assign head_inc  = (head_q == PD_W'(PENDING_DEPTH - 1)) ? '0 : head_q + 1'b1;
  assign send_head = pend_full ? head_inc : head_q;
  assign send_fill = pend_full ? PF_W'(PENDING_DEPTH - 1) : pfill_q;
  assign slot_sum  = (PF_W+1)'(send_head) + (PF_W+1)'(send_fill);
  assign send_slot = (slot_sum >= (PF_W+1)'(PENDING_DEPTH)) ?
                     PD_W'(slot_sum - (PF_W+1)'(PENDING_DEPTH)) : PD_W'(slot_sum);
  assign pend_we   = pop_o && (req_i.item.mode == MODE_SEND);

  assign pend_nonempty = (pfill_q != '0);
  assign hd_less = id_less(pend_id_rd_q, item_q.packet_id);
  assign hd_eq   = (pend_id_rd_q == item_q.packet_id);
  assign now_ge  = (item_q.time_us >= pend_time_rd_q);
  assign diff    = item_q.time_us - pend_time_rd_q;
  assign rtt_sat = (diff[63:32] != 32'd0) ? 32'hFFFF_FFFF : diff[31:0];
  assign ring_we = (state_q == S_PCHK) && (item_q.mode == MODE_ACK) && pend_nonempty &&
                   !hd_less && hd_eq && now_ge;

  assign age   = (item_q.time_us >= ring_stamp_rd_q) ? item_q.time_us - ring_stamp_rd_q
                                                     : 64'd0;
  assign fresh = (age <= {32'd0, max_age_i});

  assign nm1 = n_q - 1'b1;
  assign m50 = MW'(prod50_q) * MW'(RECIP_100);
  assign m95 = MW'(prod95_q) * MW'(RECIP_100);
  assign m99 = MW'(prod99_q) * MW'(RECIP_100);

  // sorted row: each cell takes its left neighbor, the new sample or keeps its value
  always_comb begin
    for (int i = 0; i < RING_DEPTH; i++) begin
      if (i > 0 && (RF_W'(i - 1) < n_q) &&
          (sort_q[(i > 0) ? i - 1 : 0] > ring_rtt_rd_q)) begin
        sort_ins[i] = sort_q[(i > 0) ? i - 1 : 0];
      end else if ((RF_W'(i) == n_q) ||
                   ((RF_W'(i) < n_q) && (sort_q[i] > ring_rtt_rd_q))) begin
        sort_ins[i] = ring_rtt_rd_q;
      end else begin
        sort_ins[i] = sort_q[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pend_we) begin
      pend_id_mem[send_slot]   <= req_i.item.packet_id;
      pend_time_mem[send_slot] <= req_i.item.time_us;
    end
    pend_id_rd_q   <= pend_id_mem[head_q];
    pend_time_rd_q <= pend_time_mem[head_q];
  end

  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_rtt_mem[wpos_q]   <= rtt_sat;
      ring_stamp_mem[wpos_q] <= item_q.time_us;
    end
    ring_rtt_rd_q   <= ring_rtt_mem[idx_q[RD_W-1:0]];
    ring_stamp_rd_q <= ring_stamp_mem[idx_q[RD_W-1:0]];
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      item_q <= req_i.item;
    end
    if (state_q == S_SINS && fresh) begin
      sort_q <= sort_ins;
    end else if (state_q == S_DRAIN) begin
      for (int i = 0; i < RING_DEPTH - 1; i++) begin
        sort_q[i] <= sort_q[i+1];
      end
    end
    if (state_q == S_RANK) begin
      prod50_q <= PW'(PCT_50) * PW'(nm1);
      prod95_q <= PW'(PCT_95) * PW'(nm1);
      prod99_q <= PW'(PCT_99) * PW'(nm1);
    end
    if (state_q == S_RANK2) begin
      r50_q <= m50[RECIP_SHIFT +: RF_W];
      r95_q <= m95[RECIP_SHIFT +: RF_W];
      r99_q <= m99[RECIP_SHIFT +: RF_W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      pfill_q <= '0;
      wpos_q  <= '0;
      rfill_q <= '0;
      idx_q   <= '0;
      n_q     <= '0;
      c_q     <= '0;
      res_q   <= '0;
    end else begin
      res_q.valid <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (req_i.valid) begin
            case (req_i.item.mode)
              MODE_SEND: begin
                head_q  <= send_head;
                pfill_q <= send_fill + 1'b1;
              end
              MODE_ACK, MODE_NACK: begin
                state_q <= S_PREAD;
              end
              default: begin
                idx_q   <= '0;
                n_q     <= '0;
                state_q <= S_SRD;
              end
            endcase
          end
        end
        S_PREAD: begin
          state_q <= S_PCHK;
        end
        S_PCHK: begin
          if (pend_nonempty && hd_less) begin
            head_q  <= head_inc;
            pfill_q <= pfill_q - 1'b1;
            state_q <= S_PREAD;
          end else begin
            if (pend_nonempty && hd_eq) begin
              head_q  <= head_inc;
              pfill_q <= pfill_q - 1'b1;
            end
            if (ring_we) begin
              wpos_q <= (wpos_q == RD_W'(RING_DEPTH - 1)) ? '0 : wpos_q + 1'b1;
              if (rfill_q != RF_W'(RING_DEPTH)) begin
                rfill_q <= rfill_q + 1'b1;
              end
            end
            if (item_q.mode == MODE_ACK) begin
              res_q        <= '0;
              res_q.valid  <= 1'b1;
              res_q.ack_ok <= ring_we;
              res_q.rtt_us <= ring_we ? rtt_sat : 32'd0;
            end
            state_q <= S_IDLE;
          end
        end
        S_SRD: begin
          state_q <= (idx_q == rfill_q) ? S_RANK : S_SINS;
        end
        S_SINS: begin
          if (fresh) begin
            n_q <= n_q + 1'b1;
          end
          idx_q   <= idx_q + 1'b1;
          state_q <= S_SRD;
        end
        S_RANK: begin
          if (n_q == '0) begin
            res_q       <= '0;
            res_q.valid <= 1'b1;
            res_q.kind  <= 1'b1;
            state_q     <= S_IDLE;
          end else begin
            state_q <= S_RANK2;
          end
        end
        S_RANK2: begin
          c_q     <= '0;
          state_q <= S_DRAIN;
        end
        S_DRAIN: begin
          // smallest remaining sample sits in the first cell
          if (c_q == r50_q) res_q.p50_us <= sort_q[0];
          if (c_q == r95_q) res_q.p95_us <= sort_q[0];
          if (c_q == r99_q) res_q.p99_us <= sort_q[0];
          if (c_q == '0) res_q.min_us <= sort_q[0];
          c_q <= c_q + 1'b1;
          if (c_q == nm1) begin
            res_q.max_us      <= sort_q[0];
            res_q.valid       <= 1'b1;
            res_q.kind        <= 1'b1;
            res_q.ack_ok      <= 1'b0;
            res_q.rtt_us      <= 32'd0;
            res_q.fresh_count <= 7'(n_q);
            state_q           <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: design/rtt_sample_tracker_percentiles_core.sv
// send: stored in the pending queue when the back end takes it from the front queue, no result
// ack: older pending entries are dropped, then the head is checked for the id and one result is given
// nack: handled alike but gives no result; a matched ack writes its rtt into the sample ring
// stats: reads all stored samples, sorts the fresh ones, then drains them to pick the percentiles
// a two entry queue in front takes items while the back end works, busy when it is full
// reset empties the pending queue and sample ring, age limit 2000000 us; results cannot stall
// ----------------------------------------------------------------------------
// rtt_sample_tracker_percentiles_core
// round trip time tracker with percentile statistics
// ----------------------------------------------------------------------------
module rtt_sample_tracker_percentiles_core import rtt_pkg::*; #(
  parameter int PENDING_DEPTH = 64,
  parameter int RING_DEPTH    = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode_i,
  input  logic [31:0] packet_id_i,
  input  logic [63:0] time_us_i,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] max_sample_age_us_i,
  output logic        result_strobe,
  output logic        result_kind_o,
  output logic        ack_ok_o,
  output logic [31:0] rtt_us_o,
  output logic [31:0] p50_us_o,
  output logic [31:0] p95_us_o,
  output logic [31:0] p99_us_o,
  output logic [31:0] min_us_o,
  output logic [31:0] max_us_o,
  output logic [6:0]  fresh_count_o
);

  logic [31:0] max_age_q;
  fe_req_t     req;
  logic        pop;
  result_t     res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_age_q <= MAX_AGE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_age_q <= max_sample_age_us_i;
    end
  end

  rtt_fe u_fe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .mode_i      (mode_i),
    .packet_id_i (packet_id_i),
    .time_us_i   (time_us_i),
    .busy_o      (busy),
    .req_o       (req),
    .pop_i       (pop)
  );

  rtt_be #(
    .PENDING_DEPTH (PENDING_DEPTH),
    .RING_DEPTH    (RING_DEPTH)
  ) u_be (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .max_age_i (max_age_q),
    .req_i     (req),
    .pop_o     (pop),
    .res_o     (res)
  );

  assign result_strobe = res.valid;
  assign result_kind_o = res.kind;
  assign ack_ok_o      = res.ack_ok;
  assign rtt_us_o      = res.rtt_us;
  assign p50_us_o      = res.p50_us;
  assign p95_us_o      = res.p95_us;
  assign p99_us_o      = res.p99_us;
  assign min_us_o      = res.min_us;
  assign max_us_o      = res.max_us;
  assign fresh_count_o = res.fresh_count;

endmodule

// File: design/rtt_chk.sv
// ----------------------------------------------------------------------------
// rtt_chk
// port level checks of the round trip time tracker results
// ----------------------------------------------------------------------------
module rtt_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        result_strobe,
  input logic        result_kind_o,
  input logic        ack_ok_o,
  input logic [31:0] rtt_us_o,
  input logic [31:0] p50_us_o,
  input logic [31:0] p95_us_o,
  input logic [31:0] p99_us_o,
  input logic [31:0] min_us_o,
  input logic [31:0] max_us_o,
  input logic [6:0]  fresh_count_o
);

  // ack results carry no statistics
  a_ack_no_stats: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe && !result_kind_o |-> fresh_count_o == 7'd0 && min_us_o == 32'd0 &&
      max_us_o == 32'd0 && p50_us_o == 32'd0 && p99_us_o == 32'd0)
    else $error("ack result with statistics");

  a_stats_no_rtt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe && result_kind_o |-> !ack_ok_o && rtt_us_o == 32'd0)
    else $error("stats result with rtt");

  a_failed_ack_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe && !result_kind_o && !ack_ok_o |-> rtt_us_o == 32'd0)
    else $error("failed ack with rtt");

  // percentiles come out of a sorted order
  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe && result_kind_o |-> min_us_o <= p50_us_o && p50_us_o <= p95_us_o &&
      p95_us_o <= p99_us_o && p99_us_o <= max_us_o)
    else $error("percentiles out of order");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe && result_kind_o && fresh_count_o == 7'd0 |-> max_us_o == 32'd0)
    else $error("empty statistics not zero");

endmodule

bind rtt_sample_tracker_percentiles_core rtt_chk u_chk (.*);
